FILE: src/lac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg
// Types and constants shared by the LRU address cache and its channels.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int KEY_W  = 256;
    localparam int ADDR_W = 128;
    localparam int IDX_W  = 16;
    localparam int CFG_W  = 5;

    localparam logic [3:0] F_ADD        = 4'd0;
    localparam logic [3:0] F_GET        = 4'd1;
    localparam logic [3:0] F_GET_IDX    = 4'd2;
    localparam logic [3:0] F_KEY_OF_VAL = 4'd3;
    localparam logic [3:0] F_IDX_OF_KEY = 4'd4;
    localparam logic [3:0] F_REMOVE     = 4'd5;
    localparam logic [3:0] F_REMOVE_IDX = 4'd6;
    localparam logic [3:0] F_CLEAR      = 4'd7;
    localparam logic [3:0] F_REMOVE_VAL = 4'd8;
    localparam logic [3:0] F_REMOVE_PFX = 4'd9;

    localparam logic [0:0] CFG_CACHE_LIMIT   = 1'b0;
    localparam logic [0:0] CFG_BINDING_COUNT = 1'b1;

    localparam logic [IDX_W-1:0] IDX_MAX   = 16'hFFFF;
    localparam logic [IDX_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [IDX_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [7:0]       PFX_MAX   = 8'd128;

    typedef struct packed {
        logic [3:0]       func;
        logic [63:0]      key_w3;
        logic [63:0]      key_w2;
        logic [63:0]      key_w1;
        logic [63:0]      key_w0;
        logic [63:0]      value_hi;
        logic [63:0]      value_lo;
        logic [IDX_W-1:0] entry_index;
        logic [7:0]       prefix_bits;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [63:0]      out_key_w3;
        logic [63:0]      out_key_w2;
        logic [63:0]      out_key_w1;
        logic [63:0]      out_key_w0;
        logic [63:0]      out_value_hi;
        logic [63:0]      out_value_lo;
        logic [IDX_W-1:0] out_index;
        logic [4:0]       removed;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  idx;
    } t_entry;

endpackage

FILE: src/lac_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_req_if
// Request channel of the LRU address cache: valid, ready and one item.
// ----------------------------------------------------------------------------
interface lac_req_if;
    import lac_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/lac_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_rsp_if
// Response channel of the LRU address cache: valid, ready and one item.
// ----------------------------------------------------------------------------
interface lac_rsp_if;
    import lac_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/lru_address_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_address_cache
// Maps 256-bit host keys to 128-bit addresses, kept in recency order.
//
// Requests arrive on i_req, one result item per request leaves on o_rsp.
// cache_limit and binding_count are written through i_cfg_we/i_cfg_idx/
// i_cfg_data by the user, while the block is idle; the block does not enforce it.
// Keys, addresses and indices live in one synchronous memory of ENTRIES words
// with one write and one read port; valid bits and recency ranks are
// flip-flops per entry. Each lookup, remove or add streams all ENTRIES words
// through the memory read port, one a cycle, before the result is decided;
// clear and rejected requests are answered straight from idle. An add that
// inserts a new entry passes through an insert step, and bulk removes take
// the marked entries out one by one. An add that exhausts the index range
// draws random trials from the LFSR and rescans the table for each one.
// A new item is taken only when the block is idle and the output register
// is empty, so a stalled receiver holds the block. Reset (synchronous,
// active low) empties the table and restores the generator and registers;
// the memory itself is not cleared.
// ----------------------------------------------------------------------------
module lru_address_cache #(
    parameter int ENTRIES        = 16,
    parameter int MIN_FREE_RANGE = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lac_req_if.sink                       i_req,
    lac_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [lac_pkg::CFG_W-1:0]     i_cfg_data
);
    import lac_pkg::*;

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_GTRY   = 3'd3;
    localparam logic [2:0] S_GCHK   = 3'd4;
    localparam logic [2:0] S_INSERT = 3'd5;
    localparam logic [2:0] S_REMOVE = 3'd6;

    logic [2:0]        r_state;
    logic [CFG_W-1:0]  r_limit;
    logic [CFG_W-1:0]  r_binding;
    t_req              r_req;
    logic [ADDR_W-1:0] r_pmask;

    t_entry            mem [ENTRIES];
    t_entry            r_rd;
    logic              r_we;
    logic [SW-1:0]     r_waddr;
    t_entry            r_wdata;

    logic [ENTRIES-1:0] r_valid;
    logic [SW-1:0]      r_rank [ENTRIES];
    logic [CW-1:0]      r_total;

    logic [IDX_W-1:0]  r_gen_next;
    logic [IDX_W-1:0]  r_gen_upper;
    logic [IDX_W-1:0]  r_lfsr;
    logic [IDX_W-1:0]  r_trial;
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_up;
    logic              r_hit;
    logic [IDX_W-1:0]  r_new_idx;

    logic [CW-1:0]     r_scan;
    logic              r_ev_vld;
    logic [SW-1:0]     r_ev_slot;
    logic              r_gen;

    logic              r_found;
    logic [SW-1:0]     r_best_slot;
    logic [SW-1:0]     r_best_rank;
    t_entry            r_best;
    logic [SW-1:0]     r_lru_slot;
    logic [IDX_W-1:0]  r_lru_idx;
    logic [ENTRIES-1:0] r_rm;
    logic [CW-1:0]     r_rm_cnt;

    t_rsp              r_rsp;
    logic              r_rsp_vld;

    logic [KEY_W-1:0]  key_in;
    logic [ADDR_W-1:0] val_in;
    logic              ev_match;
    logic              is_bulk;
    logic              grow;
    logic [SW-1:0]     free_slot;
    logic [SW-1:0]     rm_pick;
    logic [SW-1:0]     sel_slot;
    logic [SW-1:0]     sel_rank;
    logic              sel_valid;
    logic [IDX_W-1:0]  lfsr_n;
    logic [IDX_W:0]    span;
    logic [ADDR_W-1:0] pmask_n;
    logic              accept;
    t_rsp              clr_rsp;

    assign key_in = {r_req.key_w3, r_req.key_w2, r_req.key_w1, r_req.key_w0};
    assign val_in = {r_req.value_hi, r_req.value_lo};
    assign is_bulk = (r_req.func == F_REMOVE_VAL) || (r_req.func == F_REMOVE_PFX);
    assign accept = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_vld;
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        clr_rsp         = '0;
        clr_rsp.ok      = 1'b1;
        clr_rsp.removed = 5'(r_total);
    end

    always_comb begin
        case (r_req.func)
            F_ADD, F_GET, F_IDX_OF_KEY, F_REMOVE: ev_match = (r_rd.key == key_in);
            F_GET_IDX, F_REMOVE_IDX:              ev_match = (r_rd.idx == r_req.entry_index);
            F_KEY_OF_VAL, F_REMOVE_VAL:           ev_match = (r_rd.addr == val_in);
            F_REMOVE_PFX: ev_match = (((r_rd.addr ^ val_in) & r_pmask) == '0);
            default:                              ev_match = 1'b0;
        endcase
    end

    // Lowest free slot and lowest slot still marked for bulk removal.
    always_comb begin
        free_slot = '0;
        rm_pick   = '0;
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            if (!r_valid[j]) free_slot = SW'(j);
            if (r_rm[j]) rm_pick = SW'(j);
        end
    end

    assign sel_slot  = (r_state == S_REMOVE) ? rm_pick : r_ev_slot;
    assign sel_rank  = r_rank[sel_slot];
    assign sel_valid = r_valid[sel_slot];

    assign grow = ((8'(r_total) < 8'(r_limit)) || (8'(r_total) < 8'(r_binding)))
                  && (r_total < CW'(ENTRIES));
    assign lfsr_n = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign span = {1'b0, r_up} - {1'b0, r_lo};
    assign pmask_n = (i_req.data.prefix_bits == 8'd0) ? '0 :
                     ({ADDR_W{1'b1}} << (PFX_MAX - i_req.data.prefix_bits));

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr] <= r_wdata;
        end
        r_rd <= mem[r_scan[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= CFG_W'(16);
            r_binding   <= '0;
            r_valid     <= '0;
            r_total     <= '0;
            r_gen_next  <= '0;
            r_gen_upper <= IDX_MAX;
            r_lfsr      <= LFSR_SEED;
            r_rsp_vld   <= 1'b0;
            r_we        <= 1'b0;
            r_ev_vld    <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CACHE_LIMIT:   r_limit   <= i_cfg_data;
                    CFG_BINDING_COUNT: r_binding <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req.data;
                        r_pmask  <= pmask_n;
                        r_rsp    <= (i_req.data.func == F_CLEAR) ? clr_rsp : '0;
                        r_found  <= 1'b0;
                        r_rm     <= '0;
                        r_rm_cnt <= '0;
                        r_gen    <= 1'b0;
                        r_scan   <= '0;
                        r_ev_vld <= 1'b0;
                        if (i_req.data.func == F_CLEAR) begin
                            r_valid       <= '0;
                            r_total       <= '0;
                            r_gen_next    <= '0;
                            r_gen_upper   <= IDX_MAX;
                            r_rsp_vld     <= 1'b1;
                        end else if (i_req.data.func > F_REMOVE_PFX ||
                                     (i_req.data.func == F_REMOVE_PFX &&
                                      i_req.data.prefix_bits > PFX_MAX)) begin
                            r_rsp_vld <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_ev_vld  <= (r_scan < CW'(ENTRIES));
                    r_ev_slot <= r_scan[SW-1:0];
                    if (r_scan < CW'(ENTRIES)) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (r_ev_vld && sel_valid) begin
                        if (r_gen) begin
                            if (r_rd.idx == r_trial) r_hit <= 1'b1;
                            if (r_rd.idx > r_trial && r_rd.idx < r_up) r_up <= r_rd.idx;
                            if (r_rd.idx < r_trial && r_rd.idx > r_lo) r_lo <= r_rd.idx;
                        end else if (is_bulk) begin
                            r_rm[r_ev_slot] <= ev_match;
                        end else begin
                            if (ev_match && (!r_found || sel_rank < r_best_rank)) begin
                                r_found     <= 1'b1;
                                r_best_slot <= r_ev_slot;
                                r_best_rank <= sel_rank;
                                r_best      <= r_rd;
                            end
                            if (sel_rank == SW'(r_total - 1'b1)) begin
                                r_lru_slot <= r_ev_slot;
                                r_lru_idx  <= r_rd.idx;
                            end
                        end
                    end
                    if (r_scan == CW'(ENTRIES) && !r_ev_vld) begin
                        r_state <= r_gen ? S_GCHK : S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    case (r_req.func)
                        F_ADD: begin
                            if (r_found || (!grow && r_total != '0)) begin
                                // Update in place or overwrite the least recent entry.
                                r_we    <= 1'b1;
                                r_waddr <= r_found ? r_best_slot : r_lru_slot;
                                r_wdata <= {key_in, val_in,
                                            r_found ? r_best.idx : r_lru_idx};
                                for (int j = 0; j < ENTRIES; j++) begin
                                    if (r_valid[j] && r_rank[j] <
                                        (r_found ? r_best_rank : SW'(r_total - 1'b1))) begin
                                        r_rank[j] <= r_rank[j] + 1'b1;
                                    end
                                end
                                r_rank[r_found ? r_best_slot : r_lru_slot] <= '0;
                                r_rsp.ok        <= 1'b1;
                                r_rsp.out_index <= r_found ? r_best.idx : r_lru_idx;
                                r_rsp_vld       <= 1'b1;
                            end else if (grow) begin
                                if (r_gen_next == r_gen_upper) begin
                                    r_state <= S_GTRY;
                                end else begin
                                    r_new_idx  <= r_gen_next;
                                    r_gen_next <= r_gen_next + 1'b1;
                                    r_state    <= S_INSERT;
                                end
                            end else begin
                                r_rsp_vld <= 1'b1;
                            end
                        end
                        F_GET: begin
                            if (r_found) begin
                                for (int j = 0; j < ENTRIES; j++) begin
                                    if (r_valid[j] && r_rank[j] < r_best_rank) begin
                                        r_rank[j] <= r_rank[j] + 1'b1;
                                    end
                                end
                                r_rank[r_best_slot] <= '0;
                                r_rsp.ok           <= 1'b1;
                                r_rsp.out_value_hi <= r_best.addr[127:64];
                                r_rsp.out_value_lo <= r_best.addr[63:0];
                            end
                            r_rsp_vld <= 1'b1;
                        end
                        F_GET_IDX, F_KEY_OF_VAL: begin
                            if (r_found) begin
                                r_rsp.ok         <= 1'b1;
                                r_rsp.out_key_w3 <= r_best.key[255:192];
                                r_rsp.out_key_w2 <= r_best.key[191:128];
                                r_rsp.out_key_w1 <= r_best.key[127:64];
                                r_rsp.out_key_w0 <= r_best.key[63:0];
                                if (r_req.func == F_GET_IDX) begin
                                    r_rsp.out_value_hi <= r_best.addr[127:64];
                                    r_rsp.out_value_lo <= r_best.addr[63:0];
                                end
                            end
                            r_rsp_vld <= 1'b1;
                        end
                        F_IDX_OF_KEY: begin
                            if (r_found) begin
                                r_rsp.ok        <= 1'b1;
                                r_rsp.out_index <= r_best.idx;
                            end
                            r_rsp_vld <= 1'b1;
                        end
                        F_REMOVE, F_REMOVE_IDX: begin
                            if (r_found) begin
                                r_valid[r_best_slot] <= 1'b0;
                                for (int j = 0; j < ENTRIES; j++) begin
                                    if (r_valid[j] && r_rank[j] > r_best_rank) begin
                                        r_rank[j] <= r_rank[j] - 1'b1;
                                    end
                                end
                                r_total  <= r_total - 1'b1;
                                r_rsp.ok <= 1'b1;
                            end
                            r_rsp_vld <= 1'b1;
                        end
                        default: begin
                            r_state <= S_REMOVE;
                        end
                    endcase
                end
                S_GTRY: begin
                    r_lfsr   <= lfsr_n;
                    r_trial  <= lfsr_n;
                    r_lo     <= '0;
                    r_up     <= IDX_MAX;
                    r_hit    <= 1'b0;
                    r_gen    <= 1'b1;
                    r_scan   <= '0;
                    r_ev_vld <= 1'b0;
                    r_state  <= S_SCAN;
                end
                S_GCHK: begin
                    if (!r_hit && r_trial != IDX_MAX &&
                        span >= (IDX_W + 1)'(MIN_FREE_RANGE)) begin
                        r_gen_upper <= r_up;
                        r_new_idx   <= r_lo + 1'b1;
                        r_gen_next  <= r_lo + IDX_W'(2);
                        r_state     <= S_INSERT;
                    end else begin
                        r_state <= S_GTRY;
                    end
                end
                S_INSERT: begin
                    r_we    <= 1'b1;
                    r_waddr <= free_slot;
                    r_wdata <= {key_in, val_in, r_new_idx};
                    for (int j = 0; j < ENTRIES; j++) begin
                        if (r_valid[j]) r_rank[j] <= r_rank[j] + 1'b1;
                    end
                    r_rank[free_slot]  <= '0;
                    r_valid[free_slot] <= 1'b1;
                    r_total            <= r_total + 1'b1;
                    r_rsp.ok           <= 1'b1;
                    r_rsp.out_index    <= r_new_idx;
                    r_rsp_vld          <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_REMOVE: begin
                    // One marked entry leaves per cycle; ranks above it close the gap.
                    if (r_rm != '0) begin
                        r_valid[rm_pick] <= 1'b0;
                        r_rm[rm_pick]    <= 1'b0;
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j] && r_rank[j] > sel_rank) begin
                                r_rank[j] <= r_rank[j] - 1'b1;
                            end
                        end
                        r_total  <= r_total - 1'b1;
                        r_rm_cnt <= r_rm_cnt + 1'b1;
                    end else begin
                        r_rsp.ok      <= (r_rm_cnt != '0);
                        r_rsp.removed <= 5'(r_rm_cnt);
                        r_rsp_vld     <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_total_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_total))
        else $error("entry count differs from number of valid entries");

    a_miss_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_vld && !r_rsp.ok) |-> (r_rsp.out_index == '0))
        else $error("index reported for a failed request");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_rsp_vld)
        else $error("result pending while a request is still in work");
`endif

endmodule

FILE: tb/sv/lac_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_test_pkg
// Behavioral predictor and result scoreboard for the LRU address cache test.
// ----------------------------------------------------------------------------
package lac_test_pkg;
    import lac_pkg::*;

    localparam int N_SLOTS = 16;
    localparam int MIN_GAP = 100;

    class lac_scoreboard;
        logic [4:0]        limit_reg;
        logic [4:0]        binding_reg;
        logic [KEY_W-1:0]  keys [N_SLOTS];
        logic [ADDR_W-1:0] addrs [N_SLOTS];
        logic [IDX_W-1:0]  idxs [N_SLOTS];
        int                rank [N_SLOTS];
        bit                used [N_SLOTS];
        int                total;
        logic [IDX_W-1:0]  gen_next, gen_lower, gen_upper, lfsr;
        t_rsp              pending [$];
        int                errors;

        function new();
            limit_reg = 16;
            binding_reg = 0;
            total = 0;
            errors = 0;
            gen_next = 0;
            gen_lower = 0;
            gen_upper = IDX_MAX;
            lfsr = LFSR_SEED;
            foreach (used[s]) begin
                used[s] = 0;
                rank[s] = 0;
            end
        endfunction

        function void set_reg(logic [0:0] idx, logic [4:0] val);
            if (idx == CFG_CACHE_LIMIT) limit_reg = val;
            else binding_reg = val;
        endfunction

        function int slot_at_rank(int r);
            for (int s = 0; s < N_SLOTS; s++)
                if (used[s] && rank[s] == r) return s;
            return -1;
        endfunction

        function bit pfx_hit(int s, logic [ADDR_W-1:0] pfx, int len);
            logic [ADDR_W-1:0] mask;
            if (len == 0) return 1;
            mask = {ADDR_W{1'b1}} << (ADDR_W - len);
            return ((addrs[s] ^ pfx) & mask) == '0;
        endfunction

        // kind 0 key, 1 value, 2 index, 3 prefix; searched most recent first.
        function bit hit(int kind, int s, t_req q);
            case (kind)
                0: return keys[s] == {q.key_w3, q.key_w2, q.key_w1, q.key_w0};
                1: return addrs[s] == {q.value_hi, q.value_lo};
                2: return idxs[s] == q.entry_index;
                default: return pfx_hit(s, {q.value_hi, q.value_lo}, q.prefix_bits);
            endcase
        endfunction

        function int search(int kind, t_req q);
            int s;
            for (int r = 0; r < total; r++) begin
                s = slot_at_rank(r);
                if (s >= 0 && hit(kind, s, q)) return s;
            end
            return -1;
        endfunction

        function void promote(int s);
            for (int j = 0; j < N_SLOTS; j++)
                if (used[j] && j != s && rank[j] < rank[s]) rank[j]++;
            rank[s] = 0;
        endfunction

        function void drop(int s);
            used[s] = 0;
            for (int j = 0; j < N_SLOTS; j++)
                if (used[j] && rank[j] > rank[s]) rank[j]--;
            total--;
        endfunction

        function int drop_matching(int kind, t_req q);
            int order [$];
            int kept, gone, s;
            kept = 0;
            gone = 0;
            for (int r = 0; r < total; r++) begin
                s = slot_at_rank(r);
                if (s >= 0) order.push_back(s);
            end
            foreach (order[i]) begin
                if (hit(kind, order[i], q)) begin
                    used[order[i]] = 0;
                    gone++;
                end else begin
                    rank[order[i]] = kept++;
                end
            end
            total = kept;
            return gone;
        endfunction

        function logic [IDX_W-1:0] next_index();
            logic [IDX_W-1:0] trial, lo, up;
            bit taken;
            if (gen_next == gen_upper) begin
                lo = 0;
                up = IDX_MAX;
                for (int t = 0; t < 65536; t++) begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                    trial = lfsr;
                    taken = 0;
                    lo = 0;
                    up = IDX_MAX;
                    for (int s = 0; s < N_SLOTS; s++) begin
                        if (used[s]) begin
                            if (idxs[s] == trial) taken = 1;
                            else if (idxs[s] > trial && idxs[s] < up) up = idxs[s];
                            else if (idxs[s] < trial && idxs[s] > lo) lo = idxs[s];
                        end
                    end
                    if (!taken && trial != IDX_MAX && int'(up) - int'(lo) >= MIN_GAP)
                        break;
                end
                gen_lower = lo;
                gen_upper = up;
                gen_next = lo + 1;
            end
            return gen_next++;
        endfunction

        function void store(int s, t_req q);
            keys[s] = {q.key_w3, q.key_w2, q.key_w1, q.key_w0};
            addrs[s] = {q.value_hi, q.value_lo};
        endfunction

        function t_rsp do_add(t_req q);
            t_rsp r;
            int s, f;
            r = '0;
            s = search(0, q);
            if (s < 0) begin
                if ((total < limit_reg || total < binding_reg) && total < N_SLOTS) begin
                    f = -1;
                    for (int j = N_SLOTS - 1; j >= 0; j--) if (!used[j]) f = j;
                    if (f >= 0) begin
                        idxs[f] = next_index();
                        for (int j = 0; j < N_SLOTS; j++) if (used[j]) rank[j]++;
                        store(f, q);
                        rank[f] = 0;
                        used[f] = 1;
                        total++;
                        r.ok = 1;
                        r.out_index = idxs[f];
                        return r;
                    end
                end
                if (total == 0) return r;
                s = slot_at_rank(total - 1);
                if (s < 0) return r;
            end
            store(s, q);
            promote(s);
            r.ok = 1;
            r.out_index = idxs[s];
            return r;
        endfunction

        // Notes an accepted request and queues the result it must produce.
        function void note_request(t_req q);
            t_rsp r;
            int s, cnt;
            r = '0;
            case (q.func)
                F_ADD: r = do_add(q);
                F_GET: begin
                    s = search(0, q);
                    if (s >= 0) begin
                        r.ok = 1;
                        {r.out_value_hi, r.out_value_lo} = addrs[s];
                        promote(s);
                    end
                end
                F_GET_IDX, F_KEY_OF_VAL: begin
                    s = search(q.func == F_GET_IDX ? 2 : 1, q);
                    if (s >= 0) begin
                        r.ok = 1;
                        {r.out_key_w3, r.out_key_w2, r.out_key_w1, r.out_key_w0} = keys[s];
                        if (q.func == F_GET_IDX)
                            {r.out_value_hi, r.out_value_lo} = addrs[s];
                    end
                end
                F_IDX_OF_KEY: begin
                    s = search(0, q);
                    if (s >= 0) begin
                        r.ok = 1;
                        r.out_index = idxs[s];
                    end
                end
                F_REMOVE, F_REMOVE_IDX: begin
                    s = search(q.func == F_REMOVE ? 0 : 2, q);
                    if (s >= 0) begin
                        drop(s);
                        r.ok = 1;
                    end
                end
                F_CLEAR: begin
                    r.ok = 1;
                    r.removed = total[4:0];
                    foreach (used[j]) used[j] = 0;
                    total = 0;
                    gen_next = 0;
                    gen_lower = 0;
                    gen_upper = IDX_MAX;
                end
                F_REMOVE_VAL, F_REMOVE_PFX: begin
                    if (!(q.func == F_REMOVE_PFX && q.prefix_bits > PFX_MAX)) begin
                        cnt = drop_matching(q.func == F_REMOVE_VAL ? 1 : 3, q);
                        r.ok = cnt != 0;
                        r.removed = cnt[4:0];
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_rsp a);
            t_rsp e;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("ok", e.ok, a.ok);
            cmp("out_key_w0", e.out_key_w0, a.out_key_w0);
            cmp("out_key_w1", e.out_key_w1, a.out_key_w1);
            cmp("out_key_w2", e.out_key_w2, a.out_key_w2);
            cmp("out_key_w3", e.out_key_w3, a.out_key_w3);
            cmp("out_value_hi", e.out_value_hi, a.out_value_hi);
            cmp("out_value_lo", e.out_value_lo, a.out_value_lo);
            cmp("out_index", e.out_index, a.out_index);
            cmp("removed", e.removed, a.removed);
        endfunction
    endclass
endpackage

FILE: tb/sv/lru_address_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_address_cache_test
// Drives adds, lookups and removes into the cache with random pauses on both
// channels and checks every result against a behavioral predictor, across
// several capacity settings.
// ----------------------------------------------------------------------------
module lru_address_cache_test;
    import lac_pkg::*;
    import lac_test_pkg::*;

    localparam int N_RANDOM = 1550;
    localparam longint MAX_CYCLES = 4_000_000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [0:0] i_cfg_idx = CFG_CACHE_LIMIT;
    logic [CFG_W-1:0] i_cfg_data = '0;

    lac_req_if req_ch();
    lac_rsp_if rsp_ch();

    lru_address_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    lac_scoreboard sb = new();
    bit calm = 0;
    longint cycles = 0;

    // Small pools of keys and values so that lookups and removes find entries.
    logic [KEY_W-1:0]  key_pool [24];
    logic [ADDR_W-1:0] addr_pool [8];

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        rsp_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver with random stall bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 0;
        end else begin
            rsp_ch.ready <= 1;
        end
    end

    // Valid stays high after an accepted item until the next item, an idle
    // burst or a drain replaces it; the block is busy in between.
    task automatic send(t_req q);
        if (!calm && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.data <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(q);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [4:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req rand_req();
        t_req q;
        int pick;
        logic [KEY_W-1:0] k;
        k = key_pool[$urandom_range(0, 23)];
        q.key_w3 = k[255:192];
        q.key_w2 = k[191:128];
        q.key_w1 = k[127:64];
        q.key_w0 = k[63:0];
        {q.value_hi, q.value_lo} = addr_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 19) == 0) begin
            q.key_w0 = rnd64();
            q.key_w3 = rnd64();
            q.value_lo = rnd64();
            q.value_hi = rnd64();
        end
        q.entry_index = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        q.prefix_bits = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 130));
        pick = $urandom_range(0, 99);
        if (pick < 40) q.func = F_ADD;
        else if (pick < 50) q.func = F_GET;
        else if (pick < 57) q.func = F_GET_IDX;
        else if (pick < 63) q.func = F_KEY_OF_VAL;
        else if (pick < 70) q.func = F_IDX_OF_KEY;
        else if (pick < 78) q.func = F_REMOVE;
        else if (pick < 84) q.func = F_REMOVE_IDX;
        else if (pick < 86) q.func = F_CLEAR;
        else if (pick < 91) q.func = F_REMOVE_VAL;
        else if (pick < 97) q.func = F_REMOVE_PFX;
        else q.func = 4'($urandom_range(10, 15));
        return q;
    endfunction

    initial begin
        t_req q;
        for (int i = 0; i < 24; i++) key_pool[i] = {rnd64(), rnd64(), rnd64(), rnd64()};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 0; i < 8; i++) addr_pool[i] = {rnd64(), rnd64()};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty table with no room, then every operation.
        write_reg(CFG_CACHE_LIMIT, 0);
        write_reg(CFG_BINDING_COUNT, 0);
        q = rand_req();
        q.func = F_ADD;
        send(q);
        drain();
        write_reg(CFG_CACHE_LIMIT, 2);
        for (int i = 0; i < 4; i++) begin
            q = '0;
            q.func = F_ADD;
            {q.key_w3, q.key_w2, q.key_w1, q.key_w0} = key_pool[i];
            {q.value_hi, q.value_lo} = addr_pool[i % 2];
            send(q);
        end
        for (int f = 1; f <= 15; f++) begin
            q = '0;
            q.func = 4'(f);
            {q.key_w3, q.key_w2, q.key_w1, q.key_w0} = key_pool[3];
            {q.value_hi, q.value_lo} = addr_pool[1];
            q.entry_index = (f == 6) ? 16'h0000 : 16'h0003;
            q.prefix_bits = (f == 9) ? 8'd0 : 8'd255;
            send(q);
        end
        q = '0;
        q.func = F_REMOVE_PFX;
        q.prefix_bits = 8'd129;
        send(q);
        q.prefix_bits = 8'd128;
        q.entry_index = IDX_MAX;
        send(q);

        // Random phases over several capacity settings.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin write_reg(CFG_CACHE_LIMIT, 16); write_reg(CFG_BINDING_COUNT, 0); end
                1: begin write_reg(CFG_CACHE_LIMIT, 0); write_reg(CFG_BINDING_COUNT, 16); end
                2: begin write_reg(CFG_CACHE_LIMIT, 3); write_reg(CFG_BINDING_COUNT, 5); end
                3: begin write_reg(CFG_CACHE_LIMIT, 31); write_reg(CFG_BINDING_COUNT, 31); end
                4: begin write_reg(CFG_CACHE_LIMIT, 1); write_reg(CFG_BINDING_COUNT, 0); end
                default: begin
                    write_reg(CFG_CACHE_LIMIT, 16);
                    write_reg(CFG_BINDING_COUNT, 8);
                end
            endcase
            if (ph == 5) calm = 1;
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                if (ph == 2 && i == 100) drain();
                // Fresh keys now and then force index generation and replacement.
                if ($urandom_range(0, 9) == 0)
                    key_pool[$urandom_range(2, 23)] = {rnd64(), rnd64(), rnd64(), rnd64()};
                send(rand_req());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
src/lac_pkg.sv
src/lac_req_if.sv
src/lac_rsp_if.sv
src/lru_address_cache.sv
tb/sv/lac_test_pkg.sv
tb/sv/lru_address_cache_test.sv
